### hdl/gbs_pkg.sv
package gbs_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned LabelW = 8;
  localparam int unsigned IndexW = 16;
  localparam int unsigned AreaW  = 2 * CoordW;
  localparam int unsigned ThrW   = 9;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = ThrW;

  localparam logic [CfgIdxW-1:0] CFG_IOU_THRESHOLD  = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_CLASS_AGNOSTIC = 8'd1;

  localparam logic [ThrW-1:0]   THR_RESET = 9'd115;
  localparam logic [IndexW-1:0] INDEX_MAX = 16'hFFFF;

  // candidate box as it travels down the chain
  typedef struct packed {
    logic                     first;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [CoordW-1:0]        w;
    logic [CoordW-1:0]        h;
    logic [LabelW-1:0]        label;
    logic [AreaW-1:0]         area;
    logic [IndexW-1:0]        index;
    logic                     alive;
    logic                     stored;
  } cand_t;

endpackage

### hdl/greedy_box_suppression.sv
// Greedy non-maximum suppression over a chain of MAX_KEPT cells, each holding one kept box.
// A box is accepted in every cycle (busy_o stays low); each one walks the chain, two
// register stages per cell (overlap and intersection product, then the union threshold
// product), and a survivor is written into the first free cell it meets. The result of a
// box appears 2*MAX_KEPT+1 cycles after it is accepted, in input order, on result_valid_o
// for a single cycle: the receiver cannot stall, so it must take every strobe. Dropped
// boxes give no strobe. Configuration writes are always ready and are meant for an idle block.
module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int unsigned MAX_KEPT = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic                     first_of_set_i,
  input  logic signed [CoordW-1:0] box_x_i,
  input  logic signed [CoordW-1:0] box_y_i,
  input  logic [CoordW-1:0]        box_width_i,
  input  logic [CoordW-1:0]        box_height_i,
  input  logic [LabelW-1:0]        class_label_i,
  output logic                     result_valid_o,
  output logic [IndexW-1:0]        kept_index_o,
  output logic                     store_overflow_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i
);

  logic [ThrW-1:0] thr_q;
  logic            agn_q;

  logic              accept;
  logic [IndexW-1:0] item_index_q, item_index_d, cur_index;

  logic  ent_vld_q;
  cand_t ent_q, ent_d;

  logic  vld_c [MAX_KEPT+1];
  cand_t tok_c [MAX_KEPT+1];

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start_i & ~busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      agn_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_IOU_THRESHOLD:  thr_q <= cfg_data_i[ThrW-1:0];
        CFG_CLASS_AGNOSTIC: agn_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cur_index    = first_of_set_i ? '0 : item_index_q;
    item_index_d = item_index_q;
    if (accept) begin
      item_index_d = (cur_index < INDEX_MAX) ? cur_index + 1'b1 : cur_index;
    end
    ent_d.first  = first_of_set_i;
    ent_d.x      = box_x_i;
    ent_d.y      = box_y_i;
    ent_d.w      = box_width_i;
    ent_d.h      = box_height_i;
    ent_d.label  = class_label_i;
    ent_d.area   = AreaW'(box_width_i) * AreaW'(box_height_i);
    ent_d.index  = cur_index;
    ent_d.alive  = 1'b1;
    ent_d.stored = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_index_q <= '0;
      ent_vld_q    <= 1'b0;
    end else begin
      item_index_q <= item_index_d;
      ent_vld_q    <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign vld_c[0] = ent_vld_q;
  assign tok_c[0] = ent_q;

  for (genvar k = 0; k < MAX_KEPT; k++) begin : g_cell
    gbs_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .thr_i      (thr_q),
      .agnostic_i (agn_q),
      .vld_i      (vld_c[k]),
      .tok_i      (tok_c[k]),
      .vld_o      (vld_c[k+1]),
      .tok_o      (tok_c[k+1])
    );
  end

  assign result_valid_o   = vld_c[MAX_KEPT] & tok_c[MAX_KEPT].alive;
  assign kept_index_o     = tok_c[MAX_KEPT].index;
  assign store_overflow_o = ~tok_c[MAX_KEPT].stored;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(2*MAX_KEPT+1) vld_c[MAX_KEPT])
    else $error("transaction did not reach chain end at fixed latency");

  a_first_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && first_of_set_i |=> ent_vld_q && ent_q.index == '0)
    else $error("first box of set not given index zero");

  a_index_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !first_of_set_i |=> item_index_q >= $past(item_index_q))
    else $error("running index decreased within a set");
`endif

endmodule

### hdl/gbs_cell.sv
module gbs_cell
  import gbs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [ThrW-1:0] thr_i,
  input  logic            agnostic_i,
  input  logic            vld_i,
  input  cand_t           tok_i,
  output logic            vld_o,
  output cand_t           tok_o
);

  localparam int unsigned ExtW = CoordW + 2;
  localparam int unsigned UniW = AreaW + 1;
  localparam int unsigned LhsW = AreaW + 8;
  localparam int unsigned RhsW = ThrW + UniW;

  // held kept box
  logic                     occ_q, occ_d;
  logic signed [CoordW-1:0] kx_q, ky_q;
  logic [CoordW-1:0]        kw_q, kh_q;
  logic [LabelW-1:0]        klabel_q;
  logic [AreaW-1:0]         karea_q;

  // stage A -> B
  logic             vld_a_q;
  cand_t            tok_a_q, tok_a_d;
  logic [AreaW-1:0] inter_q, inter_d;
  logic [AreaW-1:0] area_b_q;
  logic             hit_q, hit_d;

  logic             vld_b_q;
  cand_t            tok_b_q, tok_b_d;

  logic eff_occ, store;

  logic signed [ExtW-1:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
  logic signed [ExtW-1:0] xlo, xhi, ylo, yhi, xdiff, ydiff;
  logic [CoordW-1:0]      iw, ih;

  logic [UniW-1:0] uni;
  logic [LhsW-1:0] lhs;
  logic [RhsW-1:0] rhs;
  logic            suppress;

  always_comb begin
    eff_occ = occ_q & ~(vld_i & tok_i.first);
    store   = vld_i & tok_i.alive & ~tok_i.stored & ~eff_occ;
    occ_d   = store | eff_occ;
    hit_d   = vld_i & eff_occ & (agnostic_i | (klabel_q == tok_i.label));
  end

  always_comb begin
    ax0 = ExtW'(tok_i.x);
    ay0 = ExtW'(tok_i.y);
    bx0 = ExtW'(kx_q);
    by0 = ExtW'(ky_q);
    ax1 = ax0 + $signed({2'b00, tok_i.w});
    ay1 = ay0 + $signed({2'b00, tok_i.h});
    bx1 = bx0 + $signed({2'b00, kw_q});
    by1 = by0 + $signed({2'b00, kh_q});
    xlo = (ax0 > bx0) ? ax0 : bx0;
    xhi = (ax1 < bx1) ? ax1 : bx1;
    ylo = (ay0 > by0) ? ay0 : by0;
    yhi = (ay1 < by1) ? ay1 : by1;
    xdiff = xhi - xlo;
    ydiff = yhi - ylo;
    iw = (xhi > xlo) ? xdiff[CoordW-1:0] : '0;
    ih = (yhi > ylo) ? ydiff[CoordW-1:0] : '0;
    inter_d = AreaW'(iw) * AreaW'(ih);
  end

  always_comb begin
    tok_a_d        = tok_i;
    tok_a_d.stored = tok_i.stored | store;
  end

  always_comb begin
    uni      = {1'b0, tok_a_q.area} + {1'b0, area_b_q} - {1'b0, inter_q};
    lhs      = {inter_q, 8'b0};
    rhs      = RhsW'(thr_i) * RhsW'(uni);
    suppress = hit_q & (RhsW'(lhs) > rhs);
    tok_b_d       = tok_a_q;
    tok_b_d.alive = tok_a_q.alive & ~suppress;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      occ_q   <= occ_d;
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      kx_q     <= tok_i.x;
      ky_q     <= tok_i.y;
      kw_q     <= tok_i.w;
      kh_q     <= tok_i.h;
      klabel_q <= tok_i.label;
      karea_q  <= tok_i.area;
    end
    tok_a_q  <= tok_a_d;
    inter_q  <= inter_d;
    area_b_q <= karea_q;
    hit_q    <= hit_d;
    tok_b_q  <= tok_b_d;
  end

  assign vld_o = vld_b_q;
  assign tok_o = tok_b_q;

endmodule

### tb/tb_top.sv
module tb_top;
  import gbs_pkg::*;

  localparam int unsigned MaxKept       = 64;
  localparam int unsigned PipeDepth     = 2 * MaxKept + 8;
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
  } box_t;

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic              overflow;
  } survivor_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start_i        = 1'b0;
  logic                first_of_set_i = 1'b0;
  logic [CoordW-1:0]   box_x_i        = '0;
  logic [CoordW-1:0]   box_y_i        = '0;
  logic [CoordW-1:0]   box_width_i    = '0;
  logic [CoordW-1:0]   box_height_i   = '0;
  logic [LabelW-1:0]   class_label_i  = '0;
  logic                cfg_valid_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                busy_o;
  logic                result_valid_o;
  logic [IndexW-1:0]   kept_index_o;
  logic                store_overflow_o;
  logic                cfg_ready_o;

  // suppression state mirrored from the accepted transactions
  box_t              kept_box_q   [MaxKept];
  logic [LabelW-1:0] kept_label_q [MaxKept];
  int unsigned       kept_total     = 0;
  logic [IndexW-1:0] set_position   = '0;
  logic [ThrW-1:0]   thr_model      = THR_RESET;
  logic              agnostic_model = 1'b0;

  survivor_t   survivor_q[$];
  box_t        recent_box[8];
  int unsigned recent_count    = 0;
  int unsigned sender_idle_pct = 0;
  logic        start_up        = 1'b0;
  int unsigned items_sent      = 0;
  int unsigned survivors_seen  = 0;
  int unsigned overflow_seen   = 0;
  int unsigned mismatches      = 0;
  int unsigned idle_cycles     = 0;

  greedy_box_suppression #(
    .MAX_KEPT(MaxKept)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .first_of_set_i  (first_of_set_i),
    .box_x_i         (box_x_i),
    .box_y_i         (box_y_i),
    .box_width_i     (box_width_i),
    .box_height_i    (box_height_i),
    .class_label_i   (class_label_i),
    .result_valid_o  (result_valid_o),
    .kept_index_o    (kept_index_o),
    .store_overflow_o(store_overflow_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint span_overlap(longint a0, longint alen, longint b0, longint blen);
    longint lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = ((a0 + alen) < (b0 + blen)) ? (a0 + alen) : (b0 + blen);
    return (hi > lo) ? (hi - lo) : 0;
  endfunction

  function automatic logic iou_exceeds(box_t a, box_t b, logic [ThrW-1:0] thr);
    longint iw, ih, inter, uni;
    iw = span_overlap(longint'($signed(a.x)), longint'(a.w),
                      longint'($signed(b.x)), longint'(b.w));
    ih = span_overlap(longint'($signed(a.y)), longint'(a.h),
                      longint'($signed(b.y)), longint'(b.h));
    inter = iw * ih;
    uni = longint'(a.w) * longint'(a.h) + longint'(b.w) * longint'(b.h) - inter;
    return (inter * 256) > (longint'(thr) * uni);
  endfunction

  function automatic box_t box_at(int x, int y, int w, int h);
    box_t b;
    b.x = CoordW'(x);
    b.y = CoordW'(y);
    b.w = CoordW'(w);
    b.h = CoordW'(h);
    return b;
  endfunction

  always @(posedge clk_i) begin : predict
    box_t      cand;
    survivor_t res;
    logic      keep;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IOU_THRESHOLD:  thr_model = cfg_data_i[ThrW-1:0];
        CFG_CLASS_AGNOSTIC: agnostic_model = cfg_data_i[0];
        default: ;
      endcase
    end
    if (rst_ni && start_i && !busy_o) begin
      cand = {box_x_i, box_y_i, box_width_i, box_height_i};
      if (first_of_set_i) begin
        kept_total = 0;
        set_position = '0;
      end
      res.index = set_position;
      if (set_position < INDEX_MAX) set_position = set_position + 1'b1;
      keep = 1'b1;
      for (int j = 0; j < kept_total; j++) begin
        if ((agnostic_model || kept_label_q[j] == class_label_i) &&
            iou_exceeds(cand, kept_box_q[j], thr_model)) keep = 1'b0;
      end
      if (keep) begin
        res.overflow = (kept_total >= MaxKept);
        if (!res.overflow) begin
          kept_box_q[kept_total] = cand;
          kept_label_q[kept_total] = class_label_i;
          kept_total++;
        end
        survivor_q.insert(survivor_q.size(), res);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    survivor_t want;
    if (rst_ni && result_valid_o) begin
      if (survivor_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result kept_index=%0d store_overflow=%0b",
                 $time, kept_index_o, store_overflow_o);
      end else begin
        want = survivor_q.pop_front();
        survivors_seen++;
        if (store_overflow_o === 1'b1) overflow_seen++;
        if (kept_index_o !== want.index) begin
          mismatches++;
          $display("%0t: kept_index expected %0d got %0d", $time, want.index, kept_index_o);
        end
        if (store_overflow_o !== want.overflow) begin
          mismatches++;
          $display("%0t: store_overflow expected %0b got %0b",
                   $time, want.overflow, store_overflow_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog, no transaction for %0d cycles, %0d results outstanding",
               $time, idle_cycles, survivor_q.size());
      $display("greedy_box_suppression verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_box(input logic first, input box_t b, input logic [LabelW-1:0] label);
    start_i        <= 1'b1;
    start_up        = 1'b1;
    first_of_set_i <= first;
    box_x_i        <= b.x;
    box_y_i        <= b.y;
    box_width_i    <= b.w;
    box_height_i   <= b.h;
    class_label_i  <= label;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start_i <= 1'b0;
      start_up = 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain_survivors();
    if (start_up) begin
      start_i <= 1'b0;
      start_up = 1'b0;
    end
    @(posedge clk_i);
    while (survivor_q.size() != 0) @(posedge clk_i);
  endtask

  // dropped boxes may still be in the chain, so let it empty before touching registers
  task automatic configure(input logic [ThrW-1:0] thr, input logic agnostic);
    drain_survivors();
    repeat (PipeDepth) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_IOU_THRESHOLD;
    cfg_data_i  <= CfgDataW'(thr);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= CFG_CLASS_AGNOSTIC;
    cfg_data_i  <= CfgDataW'(agnostic);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic make_candidate(input logic spread, output box_t b);
    box_t base;
    int   jit;
    if (spread) begin
      b.x = CoordW'($urandom);
      b.y = CoordW'($urandom);
      b.w = CoordW'($urandom_range(1, 256));
      b.h = CoordW'($urandom_range(1, 256));
    end else if (recent_count > 0 && $urandom_range(0, 99) < 60) begin
      base = recent_box[$urandom_range(0, recent_count - 1)];
      jit  = $urandom_range(0, 64);
      b.x  = base.x + CoordW'($urandom_range(0, 2 * jit)) - CoordW'(jit);
      b.y  = base.y + CoordW'($urandom_range(0, 2 * jit)) - CoordW'(jit);
      b.w  = base.w + CoordW'($urandom_range(0, 2 * jit)) - CoordW'(jit);
      b.h  = base.h + CoordW'($urandom_range(0, 2 * jit)) - CoordW'(jit);
    end else if ($urandom_range(0, 4) == 0) begin
      b = box_t'({$urandom, $urandom});
    end else begin
      b.x = CoordW'($urandom_range(0, 8191)) - 16'd4096;
      b.y = CoordW'($urandom_range(0, 8191)) - 16'd4096;
      b.w = CoordW'($urandom_range(16, 2048));
      b.h = CoordW'($urandom_range(16, 2048));
    end
    if (recent_count < 8) begin
      recent_box[recent_count] = b;
      recent_count++;
    end else begin
      recent_box[$urandom_range(0, 7)] = b;
    end
  endtask

  task automatic test_directed();
    send_box(1'b0, box_at(0, 0, 160, 160), 8'd0);
    send_box(1'b0, box_at(0, 0, 160, 160), 8'd0);
    send_box(1'b0, box_at(0, 0, 160, 160), 8'd1);
    send_box(1'b0, box_at(80, 0, 160, 160), 8'd0);
    send_box(1'b0, box_at(8, 8, 160, 160), 8'd0);
    send_box(1'b0, box_at(0, 0, 0, 0), 8'd2);
    send_box(1'b0, box_at(0, 0, 0, 0), 8'd2);
    send_box(1'b1, box_at(-32768, -32768, 65535, 65535), 8'd255);
    send_box(1'b0, box_at(32767, 32767, 65535, 65535), 8'd255);
    send_box(1'b0, box_at(-32768, -32768, 65535, 1), 8'd255);
    send_box(1'b0, box_at(16, 16, 65535, 65535), 8'd255);
    configure(9'd115, 1'b1);
    send_box(1'b1, box_at(100, 100, 320, 320), 8'd3);
    send_box(1'b0, box_at(100, 100, 320, 320), 8'd4);
    configure(9'd256, 1'b1);
    send_box(1'b0, box_at(100, 100, 320, 320), 8'd3);
    configure(9'd511, 1'b0);
    send_box(1'b0, box_at(100, 100, 320, 320), 8'd3);
    configure(9'd0, 1'b0);
    send_box(1'b1, box_at(0, 0, 160, 160), 8'd5);
    send_box(1'b0, box_at(160, 0, 160, 160), 8'd5);
    send_box(1'b0, box_at(319, 159, 160, 160), 8'd5);
    send_box(1'b0, box_at(0, 0, 0, 0), 8'd5);
    configure(THR_RESET, 1'b0);
  endtask

  task automatic test_store_full();
    for (int k = 0; k < MaxKept + 6; k++) begin
      send_box(k == 0, box_at(k * 64, 0, 32, 32), 8'd7);
    end
    send_box(1'b0, box_at(10 * 64, 0, 32, 32), 8'd7);
    send_box(1'b0, box_at((MaxKept + 2) * 64, 0, 32, 32), 8'd7);
    send_box(1'b0, box_at(0, 4096, 32, 32), 8'd8);
  endtask

  task automatic test_random_phase(input int unsigned n_items, input int unsigned idle_pct,
                                   input logic [ThrW-1:0] thr, input logic agnostic);
    int unsigned       done_items, set_len, n_labels;
    logic              spread, paused, first;
    box_t              b;
    logic [LabelW-1:0] label;
    configure(thr, agnostic);
    sender_idle_pct = idle_pct;
    done_items = 0;
    paused = 1'b0;
    while (done_items < n_items) begin
      set_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 30);
      spread   = (set_len > 50);
      n_labels = $urandom_range(1, 4);
      recent_count = 0;
      for (int k = 0; k < set_len && done_items < n_items; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          b     = box_t'({$urandom, $urandom});
          first = 1'($urandom_range(0, 1));
          label = LabelW'($urandom);
        end else begin
          make_candidate(spread, b);
          first = (k == 0);
          label = ($urandom_range(0, 19) == 0) ? LabelW'($urandom)
                                               : LabelW'($urandom_range(0, n_labels - 1));
        end
        send_box(first, b, label);
        done_items++;
        if (!paused && done_items >= n_items / 2) begin
          drain_survivors();
          paused = 1'b1;
        end
      end
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_store_full();
    test_random_phase(200, 0, ThrW'($urandom_range(1, 255)), 1'b0);
    test_random_phase(200, 51, 9'd200, 1'b1);
    test_random_phase(200, 0, 9'd0, 1'b0);
    test_random_phase(200, 34, ThrW'($urandom_range(64, 192)), 1'b1);
    drain_survivors();
    repeat (PipeDepth) @(posedge clk_i);
    $display("%0d boxes sent, %0d survivors checked, %0d of them past a full store",
             items_sent, survivors_seen, overflow_seen);
    $display("covered: thresholds 0 to 511, both label modes, empty unions, a full store");
    if (mismatches == 0 && survivor_q.size() == 0) begin
      $display("greedy_box_suppression verification clean");
    end else begin
      $display("greedy_box_suppression verification failed");
    end
    $finish;
  end

endmodule
